// File: hdl/modbus_rtu_response_checker_assert.svh
// assertion macros for the port-level checker file of the modbus reply checker
// expects signals named clk and rst in the scope of each use
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

// same-cycle implication, off while in reset
`define MRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define MRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/mrc_pkg.sv
// shared types, constants and the crc step for the modbus reply checker
// no dependencies
package mrc_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_ADDR   = 3'd2,
    ST_EXCEPTION  = 3'd3,
    ST_CRC_ERR    = 3'd4,
    ST_DATA_SHORT = 3'd5
  } status_t;

  localparam int unsigned NUM_REGS  = 7;
  localparam int unsigned REG_BYTES = 2 * NUM_REGS;
  localparam int unsigned HDR_BYTES = 3;
  localparam int unsigned OUT_W     = 136;

  localparam logic [7:0]  MIN_FRAME_LEN  = 8'd5;
  localparam logic [7:0]  FULL_FRAME_LEN = 8'd19;
  localparam logic [7:0]  MAX_COUNT      = 8'hFF;
  localparam logic [7:0]  EXC_FLAG       = 8'h80;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;

  typedef enum logic {
    REG_SLAVE_ADDR = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
  } in_item_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [4:0]                 pad;
    logic [NUM_REGS-1:0][15:0]  regs;
    logic [7:0]                 frame_length;
    logic [7:0]                 exception_code;
    status_t                    status;
  } result_t;

  // reflected crc-16/modbus, one byte unrolled over eight bit steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/mrc_in_reg.sv
// input register for received bytes of the modbus reply checker
// depends on mrc_pkg
module mrc_in_reg
  import mrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_take
);

  assign in_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_item <= in_item;
    end
  end

endmodule

// File: hdl/mrc_frame_check.sv
// per-frame state, crc, verdict and result register of the modbus reply checker
// depends on mrc_pkg
module mrc_frame_check
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] slave_address,
  input  logic       q_valid,
  input  in_item_t   q_item,
  output logic       q_take,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_result
);

  logic [7:0]  rx_count;
  logic [15:0] crc;
  logic [7:0]  held_0;
  logic [7:0]  held_1;
  logic [HDR_BYTES-1:0][7:0] header;
  logic [REG_BYTES-1:0][7:0] reg_bytes;

  logic [7:0]  count_next;
  logic [15:0] crc_next;
  logic [15:0] rx_crc;
  logic [7:0]  rel_pos;
  logic [3:0]  reg_idx;
  logic        in_reg_span;
  status_t     status_next;
  result_t     result_next;

  assign q_take = q_valid && (!out_valid || out_ready);

  always_comb begin
    count_next  = (rx_count == MAX_COUNT) ? MAX_COUNT : rx_count + 8'd1;
    crc_next    = (rx_count >= 8'd2) ? crc_feed(crc, held_0) : crc;
    rx_crc      = {q_item.rx_byte, held_1};
    rel_pos     = rx_count - 8'(HDR_BYTES);
    reg_idx     = rel_pos[3:0];
    in_reg_span = (rx_count >= 8'(HDR_BYTES)) &&
                  (rx_count < 8'(HDR_BYTES + REG_BYTES));

    // header and register bytes are complete whenever they are consulted
    if (count_next < MIN_FRAME_LEN) begin
      status_next = ST_TOO_SHORT;
    end else if (header[0] != slave_address) begin
      status_next = ST_BAD_ADDR;
    end else if ((header[1] & EXC_FLAG) != 8'h00) begin
      status_next = ST_EXCEPTION;
    end else if (rx_crc != crc_next) begin
      status_next = ST_CRC_ERR;
    end else if (count_next < FULL_FRAME_LEN) begin
      status_next = ST_DATA_SHORT;
    end else begin
      status_next = ST_OK;
    end

    result_next                = '0;
    result_next.status         = status_next;
    result_next.frame_length   = count_next;
    result_next.exception_code = (status_next == ST_EXCEPTION) ? header[2] : 8'h00;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (status_next == ST_OK) begin
        result_next.regs[k] = {reg_bytes[2*k], reg_bytes[2*k+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count   <= '0;
      crc        <= CRC_INIT;
      held_0     <= '0;
      held_1     <= '0;
      header     <= '0;
      reg_bytes  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (q_take && q_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (q_take) begin
        if (q_item.last) begin
          // frame done, back to the idle frame state
          rx_count   <= '0;
          crc        <= CRC_INIT;
          held_0     <= '0;
          held_1     <= '0;
          header     <= '0;
          reg_bytes  <= '0;
        end else begin
          rx_count   <= count_next;
          crc        <= crc_next;
          held_0     <= held_1;
          held_1     <= q_item.rx_byte;
          for (int i = 0; i < HDR_BYTES; i++) begin
            if (rx_count == 8'(i)) begin
              header[i] <= q_item.rx_byte;
            end
          end
          for (int j = 0; j < REG_BYTES; j++) begin
            if (in_reg_span && reg_idx == 4'(j)) begin
              reg_bytes[j] <= q_item.rx_byte;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_item.last) begin
      out_result <= result_next;
    end
  end

endmodule

// File: hdl/mrc_cfg.sv
// apb register block holding the expected slave address
// depends on mrc_pkg
module mrc_cfg
  import mrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  slave_address
);

  reg_index_t idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDR_RST;
    end else if (wr_en && idx == REG_SLAVE_ADDR && paddr[1:0] == 2'b00) begin
      slave_address <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLAVE_ADDR: prdata = (paddr[1:0] == 2'b00) ? {24'h0, slave_address} : 32'h0;
      default:        prdata = 32'h0;
    endcase
  end

endmodule

// File: hdl/modbus_rtu_response_checker.sv
// Modbus RTU reply checker, top level
// depends on mrc_pkg, mrc_in_reg, mrc_frame_check, mrc_cfg
//
// The slave stream takes one received reply byte per transaction; tlast marks
// the final byte of the frame. One result transaction leaves on the master
// stream for every frame, on its final byte, and none for the other bytes.
// A byte is taken every cycle unless a result is stalled on the master stream:
// the per-byte crc step is one unrolled byte update between the input register
// and the frame state, so the throughput is one byte per cycle. The final byte
// passes the input register, then the result register, before m_axis_tvalid
// rises and the result can be taken.
// While the receiver holds m_axis_tready low the result waits in the result
// register; one more byte can enter the input register, then s_axis_tready
// stays low until the result has gone.
// The APB port holds the expected slave address at byte address 0.
// Reset clears the frame state and both stream stages and sets the slave
// address to 1; nothing needs a clearing pass.
module modbus_rtu_response_checker
  import mrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  input  logic               s_axis_tlast,   // end_of_frame
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status[2:0], exception_code, frame_length, register_0 .. register_6, zero pad
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  in_item_t   in_item;
  in_item_t   q_item;
  logic       q_valid;
  logic       q_take;
  logic [7:0] slave_address;
  result_t    out_result;

  assign in_item.rx_byte = s_axis_tdata;
  assign in_item.last    = s_axis_tlast;
  assign m_axis_tdata    = out_result;

  mrc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  mrc_frame_check u_check (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_result    (out_result)
  );

  mrc_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .slave_address (slave_address)
  );

endmodule

// File: hdl/mrc_checker.sv
// port-level checks for the modbus reply checker, bound to the top level
// depends on mrc_pkg and modbus_rtu_response_checker_assert.svh
`include "modbus_rtu_response_checker_assert.svh"

module mrc_checker
  import mrc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result stays put
  `MRC_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // register fields only carry data on a good frame
  `MRC_ASSERT_IMP(a_regs_zero, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK, m_axis_tdata[130:19] == '0)

  // exception code only with an exception verdict
  `MRC_ASSERT_IMP(a_exc_zero, m_axis_tvalid && m_axis_tdata[2:0] != ST_EXCEPTION, m_axis_tdata[10:3] == 8'h00)

  // any verdict past the length test implies a frame of at least the minimum length
  `MRC_ASSERT_IMP(a_len, m_axis_tvalid && m_axis_tdata[2:0] != ST_TOO_SHORT, m_axis_tdata[18:11] >= MIN_FRAME_LEN)

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb.sv
// testbench for modbus_rtu_response_checker: streams reply frames byte by byte,
// predicts each verdict in a local crc/frame tracker and checks every result
// depends on mrc_pkg and the modbus_rtu_response_checker rtl
module tb;
  import mrc_pkg::*;

  typedef enum int {CRC_GOOD, CRC_BAD, CRC_NONE} crc_mode_e;

  localparam logic [2:0] ADDR_SLAVE    = 3'(4 * int'(REG_SLAVE_ADDR));
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [7:0] FN_READ       = 8'h03;
  localparam int         PHASE_BYTES   = 250;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'h00;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = 3'd0;
  logic [31:0]      pwdata = 32'd0;
  logic [31:0]      prdata;
  logic             pready;

  modbus_rtu_response_checker i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // pending bytes, expected verdicts
  in_item_t   byte_q [$];
  result_t    verdict_q [$];
  logic [7:0] frame_buf [$];
  int         pushed = 0;
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         s_took = 1'b0;
  int         s_gap = 0;
  int         m_gap = 0;
  result_t    got;
  result_t    want;

  // local copy of the frame tracker state
  logic [7:0]  cfg_slave = SLAVE_ADDR_RST;
  logic [7:0]  fr_count = 8'd0;
  logic [15:0] fr_crc = CRC_INIT;
  logic [7:0]  fr_hold [2] = '{default: 8'h00};
  logic [7:0]  fr_hdr [HDR_BYTES] = '{default: 8'h00};
  logic [7:0]  fr_regs [REG_BYTES] = '{default: 8'h00};

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  task automatic track_reply_byte(input logic [7:0] b, input logic eof);
    result_t     r;
    logic [15:0] rx_crc;
    if (fr_count < HDR_BYTES) fr_hdr[fr_count] = b;
    else if (fr_count < HDR_BYTES + REG_BYTES) fr_regs[fr_count - HDR_BYTES] = b;
    // the two newest bytes stay out of the crc and are compared with it when the frame ends
    if (fr_count >= 8'd2) fr_crc = crc16_byte(fr_crc, fr_hold[0]);
    fr_hold[0] = fr_hold[1];
    fr_hold[1] = b;
    if (fr_count != MAX_COUNT) fr_count = fr_count + 8'd1;
    if (eof) begin
      r = '0;
      rx_crc = {fr_hold[1], fr_hold[0]};
      if (fr_count < MIN_FRAME_LEN) r.status = ST_TOO_SHORT;
      else if (fr_hdr[0] != cfg_slave) r.status = ST_BAD_ADDR;
      else if ((fr_hdr[1] & EXC_FLAG) != 8'h00) begin
        r.status = ST_EXCEPTION;
        r.exception_code = fr_hdr[2];
      end else if (rx_crc != fr_crc) r.status = ST_CRC_ERR;
      else if (fr_count < FULL_FRAME_LEN) r.status = ST_DATA_SHORT;
      else r.status = ST_OK;
      r.frame_length = fr_count;
      if (r.status == ST_OK) begin
        for (int k = 0; k < NUM_REGS; k++) r.regs[k] = {fr_regs[2*k], fr_regs[2*k+1]};
      end
      verdict_q.push_back(r);
      fr_count = 8'd0;
      fr_crc = CRC_INIT;
      fr_hold = '{default: 8'h00};
      fr_hdr = '{default: 8'h00};
      fr_regs = '{default: 8'h00};
    end
  endtask

  task automatic cmp_field(input string name, input int unsigned want_v,
                           input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // append crc (unless mode is CRC_NONE) to the frame under construction and queue its bytes
  task automatic close_frame(input crc_mode_e mode);
    logic [15:0] c;
    c = CRC_INIT;
    if (mode != CRC_NONE) begin
      foreach (frame_buf[i]) c = crc16_byte(c, frame_buf[i]);
      if (mode == CRC_BAD) c = c ^ (16'd1 << $urandom_range(0, 15));
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
    end
    foreach (frame_buf[i]) byte_q.push_back('{frame_buf[i], i == frame_buf.size() - 1});
    pushed += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic long_frame(input logic [7:0] slave);
    frame_buf.push_back(slave);
    frame_buf.push_back(FN_READ);
    repeat ($urandom_range(252, 290)) frame_buf.push_back(8'($urandom));
    close_frame(CRC_GOOD);
  endtask

  task automatic random_frame(input logic [7:0] slave);
    int         kind;
    logic [7:0] fn;
    kind = $urandom_range(0, 99);
    fn = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127)) : FN_READ;
    if (kind < 60) begin
      // register read reply, sometimes with trailing bytes
      frame_buf.push_back(slave);
      frame_buf.push_back(fn);
      frame_buf.push_back(8'(REG_BYTES));
      repeat (REG_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0))
        frame_buf.push_back(8'($urandom));
      close_frame(kind < 50 ? CRC_GOOD : CRC_BAD);
    end else if (kind < 68) begin
      frame_buf.push_back(slave);
      frame_buf.push_back(fn | EXC_FLAG);
      frame_buf.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
      close_frame(($urandom_range(0, 3) == 0) ? CRC_BAD : CRC_GOOD);
    end else if (kind < 75) begin
      frame_buf.push_back(slave ^ 8'($urandom_range(1, 255)));
      repeat ($urandom_range(2, 17)) frame_buf.push_back(8'($urandom));
      close_frame(CRC_GOOD);
    end else if (kind < 83) begin
      frame_buf.push_back(($urandom_range(0, 1) == 0) ? slave : 8'($urandom));
      repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
      close_frame(CRC_NONE);
    end else if (kind < 93) begin
      // passes the crc but too few bytes for seven registers
      frame_buf.push_back(slave);
      frame_buf.push_back(fn);
      repeat ($urandom_range(1, 14)) frame_buf.push_back(8'($urandom));
      close_frame(CRC_GOOD);
    end else begin
      repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
      close_frame(CRC_NONE);
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SLAVE) cfg_slave = data[7:0];
  endtask

  task automatic drain;
    while (byte_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // byte sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_took) begin
      // hold the transaction until it is taken
    end else if (s_gap > 0) begin
      s_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (byte_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      s_gap = $urandom_range(0, 9);
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= byte_q[0].rx_byte;
      s_axis_tlast <= byte_q[0].last;
    end
    s_took = 1'b0;
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (m_gap > 0) begin
      m_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_gap = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      track_reply_byte(s_axis_tdata, s_axis_tlast);
      void'(byte_q.pop_front());
      s_took = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        cmp_field("status", int'(want.status), int'(got.status));
        cmp_field("exception_code", want.exception_code, got.exception_code);
        cmp_field("frame_length", want.frame_length, got.frame_length);
        for (int k = 0; k < NUM_REGS; k++)
          cmp_field($sformatf("register_%0d", k), want.regs[k], got.regs[k]);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one-byte frame, exception reply, full reply with extreme data
    frame_buf.push_back(cfg_slave);
    close_frame(CRC_NONE);
    frame_buf = '{cfg_slave, FN_READ | EXC_FLAG, 8'h02};
    close_frame(CRC_GOOD);
    frame_buf = '{cfg_slave, FN_READ, 8'(REG_BYTES), 8'hFF, 8'hFF, 8'h00, 8'h00,
                  8'h80, 8'h01, 8'h7F, 8'hFE};
    repeat (6) frame_buf.push_back(8'($urandom));
    close_frame(CRC_GOOD);
    while (pushed < PHASE_BYTES) random_frame(cfg_slave);
    drain();

    apb_write(ADDR_SLAVE, 32'h0000_0000);
    long_frame(cfg_slave);
    while (pushed < 2 * PHASE_BYTES + 300) random_frame(cfg_slave);
    drain();

    apb_write(ADDR_SLAVE, 32'h0000_00FF);
    long_frame(cfg_slave);
    while (pushed < 3 * PHASE_BYTES + 600) random_frame(cfg_slave);
    drain();

    apb_write(ADDR_SLAVE, $urandom);
    while (pushed < 4 * PHASE_BYTES + 600) random_frame(cfg_slave);
    drain();

    // unmapped index must leave the slave address alone
    apb_write(ADDR_UNMAPPED, $urandom);
    calm = 1'b1;
    while (pushed < 5 * PHASE_BYTES + 600) random_frame(cfg_slave);
    drain();

    if (verdict_q.size() != 0) begin
      $display("%0t: %0d results missing, expected 0 pending, actual %0d",
               $time, verdict_q.size(), verdict_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mrc_pkg.sv
hdl/mrc_in_reg.sv
hdl/mrc_frame_check.sv
hdl/mrc_cfg.sv
hdl/modbus_rtu_response_checker.sv
hdl/mrc_checker.sv
verif/tb.sv
